FILE: rtl/qdre_pkg.sv
// Shared widths, constants and types of the quantized delta run-length encoder.
package qdre_pkg;

  // Field widths
  localparam int SAMPLE_W    = 33;
  localparam int S_TDATA_W   = 40;
  localparam int TOKEN_W     = 28;
  localparam int M_TDATA_W   = 32;
  localparam int M_TUSER_W   = 2;

  // Arithmetic widths
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int STEP_W      = DIFF_W - 8 + 1;
  localparam int RS_W        = 26;
  localparam int ERR_W       = 18;

  // Defaults
  localparam int DEFAULT_MAX_SAMPLES = 65536;
  localparam int FIFO_DEPTH          = 4;
  localparam int MIN_KEEP_SAMPLES    = 4;

  // Bit positions in m_axis_tuser
  localparam int TUSER_IS_COUNT = 0;
  localparam int TUSER_KEEP     = 1;

  // Token sequencer phases of the back end
  typedef enum logic [2:0] {
    PH_FIRST,
    PH_A0,
    PH_A1,
    PH_AC,
    PH_B0,
    PH_B1,
    PH_BC
  } phase_t;

endpackage

FILE: rtl/qdre_fifo.sv
// Small register FIFO that decouples the front end from the token back end.
module qdre_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = qdre_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/qdre_front.sv
// Front end: quantizes the sample differences and tracks runs, one sample per cycle while fifo_full is low.
module qdre_front #(
  parameter  int MAX_SAMPLES = qdre_pkg::DEFAULT_MAX_SAMPLES,
  localparam int CW          = $clog2(MAX_SAMPLES + 1),
  localparam int ENTRY_W     = 2 * (qdre_pkg::TOKEN_W + CW) + 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [qdre_pkg::SAMPLE_W-1:0] sample_fine,
  input  logic                              last_sample,
  output logic                              push,
  output logic [ENTRY_W-1:0]                push_data,
  input  logic                              fifo_full
);

  localparam int SW = qdre_pkg::SAMPLE_W;
  localparam int DW = qdre_pkg::DIFF_W;
  localparam int PW = qdre_pkg::STEP_W;
  localparam int RW = qdre_pkg::RS_W;
  localparam int EW = qdre_pkg::ERR_W;
  localparam int TW = qdre_pkg::TOKEN_W;
  localparam int FW = DW - 8;
  localparam int XW = TW + 1;

  typedef struct packed {
    logic                 a_valid;
    logic signed [TW-1:0] a_value;
    logic [CW-1:0]        a_len;
    logic                 b_valid;
    logic signed [TW-1:0] b_value;
    logic [CW-1:0]        b_len;
    logic                 keep;
  } entry_t;

  // Divide by 256 with round half to even
  function automatic logic signed [PW-1:0] rne256(input logic signed [DW-1:0] x);
    logic [FW-1:0] fl;
    logic [7:0]    r;
    logic          up;
    fl = x[DW-1:8];
    r  = x[7:0];
    up = r[7] && ((r[6:0] != 7'd0) || fl[0]);
    return $signed({fl[FW-1], fl}) + $signed({{FW{1'b0}}, up});
  endfunction

  logic en;
  assign en       = !fifo_full;
  assign in_ready = en;

  // Stage 1: rounded sample and rounded step
  logic                 s1_v;
  logic                 s1_last;
  logic signed [PW-1:0] s1_step;
  logic [EW-1:0]        s1_q;
  logic signed [SW-1:0] prev_s;
  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] q_full;

  assign diff   = $signed({sample_fine[SW-1], sample_fine}) - $signed({prev_s[SW-1], prev_s});
  assign q_full = rne256($signed({sample_fine[SW-1], sample_fine}));

  always_ff @(posedge clk) begin
    if (en) begin
      s1_step <= rne256(diff);
      s1_q    <= q_full[EW-1:0];
      s1_last <= last_sample;
    end
  end

  // Stage 2: running sum and error-feedback term
  logic                 s2_v;
  logic                 s2_last;
  logic signed [PW-1:0] s2_step;
  logic [EW-1:0]        s2_err;
  logic [RW-1:0]        rs;
  logic [RW-1:0]        rs_new;

  assign rs_new = rs + s1_step[RW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      s2_step <= s1_step;
      s2_err  <= s1_q - rs_new[EW-1:0];
      s2_last <= s1_last;
    end
  end

  // Stage 3: coded difference, saturated to token width
  logic                 s3_v;
  logic                 s3_last;
  logic signed [TW-1:0] s3_d;
  logic [EW-1:0]        prev_err;
  logic signed [XW-1:0] d_full;
  logic signed [TW-1:0] d_sat;

  assign d_full = $signed({{(XW-PW){s2_step[PW-1]}}, s2_step})
                + $signed({{(XW-EW){s2_err[EW-1]}}, s2_err})
                - $signed({{(XW-EW){prev_err[EW-1]}}, prev_err});

  always_comb begin
    if (d_full[XW-1] != d_full[XW-2]) begin
      d_sat = d_full[XW-1] ? $signed({1'b1, {(TW-1){1'b0}}}) : $signed({1'b0, {(TW-1){1'b1}}});
    end else begin
      d_sat = d_full[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_d    <= d_sat;
      s3_last <= s2_last;
    end
  end

  // Per-shape state of the first three stages, cleared after the last sample
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      s3_v     <= 1'b0;
      prev_s   <= '0;
      rs       <= '0;
      prev_err <= '0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      if (in_valid) begin
        prev_s <= last_sample ? '0 : sample_fine;
      end
      if (s1_v) begin
        rs <= s1_last ? '0 : rs_new;
      end
      if (s2_v) begin
        prev_err <= s2_last ? '0 : s2_err;
      end
    end
  end

  // Run tracking and shape counters
  logic signed [TW-1:0] rv;
  logic [CW-1:0]        rl;
  logic [CW-1:0]        ss;
  logic [CW-1:0]        ts;
  logic                 emit_a;
  logic signed [TW-1:0] rv_upd;
  logic [CW-1:0]        rl_upd;
  logic [2:0]           n_a;
  logic [2:0]           n_b;
  logic [CW:0]          tok_sum;
  logic [CW-1:0]        ts_next;
  logic [CW-1:0]        ss_next;
  logic                 keep;
  entry_t               entry;

  always_comb begin
    emit_a = (rl != '0) && (s3_d != rv);
    if ((rl == '0) || emit_a) begin
      rv_upd = s3_d;
      rl_upd = CW'(1);
    end else begin
      rv_upd = rv;
      rl_upd = (rl < CW'(MAX_SAMPLES)) ? rl + 1'b1 : rl;
    end
    n_a     = emit_a ? ((rl > CW'(1)) ? 3'd3 : 3'd1) : 3'd0;
    n_b     = s3_last ? ((rl_upd > CW'(1)) ? 3'd3 : 3'd1) : 3'd0;
    tok_sum = {1'b0, ts} + (CW+1)'(n_a) + (CW+1)'(n_b);
    ts_next = (tok_sum > (CW+1)'(MAX_SAMPLES)) ? CW'(MAX_SAMPLES) : tok_sum[CW-1:0];
    ss_next = (ss < CW'(MAX_SAMPLES)) ? ss + 1'b1 : ss;
    keep    = (ss_next > CW'(qdre_pkg::MIN_KEEP_SAMPLES)) && (ts_next < ss_next);

    entry.a_valid = emit_a;
    entry.a_value = rv;
    entry.a_len   = rl;
    entry.b_valid = s3_last;
    entry.b_value = rv_upd;
    entry.b_len   = rl_upd;
    entry.keep    = keep;
  end

  assign push      = s3_v && en && (emit_a || s3_last);
  assign push_data = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= '0;
      rl <= '0;
      ss <= '0;
      ts <= '0;
    end else if (s3_v && en) begin
      if (s3_last) begin
        rv <= '0;
        rl <= '0;
        ss <= '0;
        ts <= '0;
      end else begin
        rv <= rv_upd;
        rl <= rl_upd;
        ss <= ss_next;
        ts <= ts_next;
      end
    end
  end

endmodule

FILE: rtl/qdre_back.sv
// Back end: expands queued runs into tokens and holds them in the output register.
module qdre_back #(
  parameter  int MAX_SAMPLES = qdre_pkg::DEFAULT_MAX_SAMPLES,
  localparam int CW          = $clog2(MAX_SAMPLES + 1),
  localparam int ENTRY_W     = 2 * (qdre_pkg::TOKEN_W + CW) + 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                head_valid,
  input  logic [ENTRY_W-1:0]                  head_data,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qdre_pkg::TOKEN_W-1:0] token,
  output logic                                token_is_count,
  output logic                                end_of_shape,
  output logic                                keep_encoding
);

  localparam int TW = qdre_pkg::TOKEN_W;

  typedef struct packed {
    logic                 a_valid;
    logic signed [TW-1:0] a_value;
    logic [CW-1:0]        a_len;
    logic                 b_valid;
    logic signed [TW-1:0] b_value;
    logic [CW-1:0]        b_len;
    logic                 keep;
  } entry_t;

  entry_t               e;
  qdre_pkg::phase_t     phase;
  qdre_pkg::phase_t     phase_next;
  qdre_pkg::phase_t     cur;
  logic                 load;
  logic                 done;
  logic signed [TW-1:0] tok;
  logic                 tok_cnt;
  logic                 tok_end;
  logic [CW-1:0]        cnt;

  assign e    = head_data;
  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && done;

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= qdre_pkg::PH_FIRST;
    end else if (load) begin
      phase <= phase_next;
    end
  end

  // Token selection and next phase
  always_comb begin
    if (phase == qdre_pkg::PH_FIRST) begin
      cur = e.a_valid ? qdre_pkg::PH_A0 : qdre_pkg::PH_B0;
    end else begin
      cur = phase;
    end
    tok        = e.a_value;
    tok_cnt    = 1'b0;
    tok_end    = 1'b0;
    cnt        = e.a_len - CW'(2);
    done       = 1'b0;
    phase_next = qdre_pkg::PH_FIRST;
    case (cur)
      qdre_pkg::PH_A0: begin
        if (e.a_len > CW'(1)) begin
          phase_next = qdre_pkg::PH_A1;
        end else if (e.b_valid) begin
          phase_next = qdre_pkg::PH_B0;
        end else begin
          done = 1'b1;
        end
      end
      qdre_pkg::PH_A1: begin
        phase_next = qdre_pkg::PH_AC;
      end
      qdre_pkg::PH_AC: begin
        tok     = TW'(cnt);
        tok_cnt = 1'b1;
        if (e.b_valid) begin
          phase_next = qdre_pkg::PH_B0;
        end else begin
          done = 1'b1;
        end
      end
      qdre_pkg::PH_B0: begin
        tok = e.b_value;
        if (e.b_len > CW'(1)) begin
          phase_next = qdre_pkg::PH_B1;
        end else begin
          done    = 1'b1;
          tok_end = 1'b1;
        end
      end
      qdre_pkg::PH_B1: begin
        tok        = e.b_value;
        phase_next = qdre_pkg::PH_BC;
      end
      qdre_pkg::PH_BC: begin
        cnt     = e.b_len - CW'(2);
        tok     = TW'(cnt);
        tok_cnt = 1'b1;
        tok_end = 1'b1;
        done    = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token          <= tok;
      token_is_count <= tok_cnt;
      end_of_shape   <= tok_end;
      keep_encoding  <= tok_end && e.keep;
    end
  end

endmodule

FILE: rtl/quantized_delta_rle_encoder.sv
// Top level of the quantized delta run-length encoder.
//
// Usage:
//   Samples enter on the s_axis channel, one item per sample; s_axis_tlast
//   marks the final sample of a shape. Tokens leave on the m_axis channel:
//   a value token, or after two equal values a run count (length minus two),
//   flagged in m_axis_tuser. m_axis_tlast marks the last token of a shape,
//   where m_axis_tuser reports whether the encoding beat a sample count above MIN_KEEP_SAMPLES.
// Throughput: one sample per cycle while the queue has room. A sample yields
//   zero to six tokens; they leave at one per cycle while m_axis_tready is high,
//   so the rate is bounded by the token count.
// Path: the sample that closes a run passes three arithmetic stages, then the run
//   tracker writes the queue and the token sequencer loads the run's first token.
// Stalls: a four-entry queue sits between the front end and the token
//   sequencer; s_axis_tready drops only while that queue is full, so the
//   input keeps flowing while a token waits on m_axis.
// Reset: synchronous; clears the pipeline, the queue and all shape state.
//   Each shape also restarts from the zero state after its last sample.
module quantized_delta_rle_encoder #(
  parameter int MAX_SAMPLES = qdre_pkg::DEFAULT_MAX_SAMPLES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [qdre_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [32:0] sample_fine, rest zero
  input  logic                               s_axis_tlast,  // last_sample
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [qdre_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // [27:0] token, rest zero
  output logic [qdre_pkg::M_TUSER_W-1:0]     m_axis_tuser,  // [0] token_is_count, [1] keep_encoding
  output logic                               m_axis_tlast   // end_of_shape
);

  localparam int CW      = $clog2(MAX_SAMPLES + 1);
  localparam int ENTRY_W = 2 * (qdre_pkg::TOKEN_W + CW) + 3;
  localparam int TW      = qdre_pkg::TOKEN_W;

  logic                 push;
  logic [ENTRY_W-1:0]   push_data;
  logic                 fifo_full;
  logic                 pop;
  logic                 head_valid;
  logic [ENTRY_W-1:0]   head_data;
  logic signed [TW-1:0] token;
  logic                 token_is_count;
  logic                 keep_encoding;

  qdre_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .sample_fine ($signed(s_axis_tdata[qdre_pkg::SAMPLE_W-1:0])),
    .last_sample (s_axis_tlast),
    .push        (push),
    .push_data   (push_data),
    .fifo_full   (fifo_full)
  );

  qdre_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(qdre_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  qdre_back #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_data      (head_data),
    .pop            (pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .token          (token),
    .token_is_count (token_is_count),
    .end_of_shape   (m_axis_tlast),
    .keep_encoding  (keep_encoding)
  );

  // Output packing
  assign m_axis_tdata = {{(qdre_pkg::M_TDATA_W - TW){1'b0}}, token};
  assign m_axis_tuser = {keep_encoding, token_is_count};

endmodule

FILE: rtl/qdre_checker.sv
// Port-level checks of the encoder, bound to the top level.
module qdre_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [qdre_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [qdre_pkg::M_TUSER_W-1:0] m_axis_tuser,
  input logic                           m_axis_tlast
);

  // A stalled token holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled token changed");

  // The keep flag only rides on the last token of a shape
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[qdre_pkg::TUSER_KEEP] |-> m_axis_tlast)
    else $error("keep flag outside end of shape");

  // A run count is never negative
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[qdre_pkg::TUSER_IS_COUNT]
      |-> !m_axis_tdata[qdre_pkg::TOKEN_W-1])
    else $error("negative run count");

  // Nothing is offered right after reset
  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("token offered after reset");

endmodule

bind quantized_delta_rle_encoder qdre_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
